@@ rtl/fsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_pkg: shared types and constants of the sand cell grid
// Cell kinds, request codes, sequencer states, probe order and the colour table.
// ----------------------------------------------------------------------------
package fsg_pkg;

	typedef enum logic [1:0] {
		KIND_AIR   = 2'd0,
		KIND_SAND  = 2'd1,
		KIND_STONE = 2'd2
	} fsg_kind_t;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_STEP   = 2'd1,
		REQ_READ   = 2'd2
	} fsg_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SETTLE,
		ST_EVAL,
		ST_WRITE_DST,
		ST_WRITE_SRC,
		ST_DONE
	} fsg_state_t;

	// Order in which the neighborhood of a cell is fetched
	typedef enum logic [2:0] {
		PRB_CTR   = 3'd0,
		PRB_DOWN  = 3'd1,
		PRB_DR    = 3'd2,
		PRB_RIGHT = 3'd3,
		PRB_DL    = 3'd4,
		PRB_LEFT  = 3'd5
	} fsg_probe_t;

	localparam int unsigned NUM_PROBES = 6;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} fsg_rgb_t;

	localparam fsg_rgb_t COL_AIR   = '{red: 8'd255, green: 8'd255, blue: 8'd255};
	localparam fsg_rgb_t COL_SAND  = '{red: 8'd243, green: 8'd236, blue: 8'd143};
	localparam fsg_rgb_t COL_STONE = '{red: 8'd170, green: 8'd170, blue: 8'd170};

	function automatic fsg_rgb_t fsg_colour(input logic [1:0] kind);
		fsg_rgb_t c;
		case (kind)
			KIND_SAND:  c = COL_SAND;
			KIND_STONE: c = COL_STONE;
			default:    c = COL_AIR;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/fsg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_if: request and response channels of the sand cell grid
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fsg_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [1:0] material;

	modport source (output valid, req_type, pos_x, pos_y, material, input ready);
	modport sink   (input valid, req_type, pos_x, pos_y, material, output ready);
endinterface

interface fsg_rsp_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic [7:0] new_x;
	logic [7:0] new_y;
	logic [1:0] cell_kind;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, ok, new_x, new_y, cell_kind, red, green, blue,
		input ready);
	modport sink   (input valid, ok, new_x, new_y, cell_kind, red, green, blue,
		output ready);
endinterface

@@ rtl/fsg_cell_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_cell_ram: grid cell storage
// Simple dual-port memory of 2-bit cells, one write and one registered read.
// ----------------------------------------------------------------------------
module fsg_cell_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/falling_sand_cell_grid_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_cell_grid_core: grid of air, sand and stone cells
// Serves create, step and read requests against a cell memory.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)  : one beat per request (req_type, pos_x, pos_y, material).
//   rsp  (source): exactly one beat per request, in request order.
//   After reset the block sweeps all GRID_WIDTH*GRID_HEIGHT cells (65536
//   at default size) of the cell memory to air, one cell per cycle;
//   req.ready stays low until the sweep ends.
//   Each request is handled alone by a sequencer around one memory with a
//   registered read: a create or read fetches one cell, a step fetches the
//   cell and its five neighbors, one per cycle. A successful create writes
//   one cell; a step that moves writes two, the destination and then the
//   source as air. The response turns valid in the same cycle in which
//   the sequencer is back in idle and can accept the next request.
//   The response sits in an output register; the next request is accepted
//   while it waits. If rsp.ready stays low, the sequencer holds at its
//   final cycle until the register frees up.
// ----------------------------------------------------------------------------
module falling_sand_cell_grid_core #(
	parameter int GRID_WIDTH  = 256,
	parameter int GRID_HEIGHT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	fsg_req_if.sink   req,
	fsg_rsp_if.source rsp
);

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// State
	fsg_pkg::fsg_state_t state_q, state_nxt;
	logic [AW-1:0]       clr_cnt_q;
	fsg_pkg::fsg_probe_t rd_cnt_q, rd_tag_s1;
	logic                rd_vld_s1;
	logic [1:0]          cell_q [fsg_pkg::NUM_PROBES];

	// Latched request
	logic [1:0] req_q;
	logic [7:0] x_q, y_q;
	logic [1:0] mat_q;
	logic       inside_q;

	// Decision of the evaluate cycle
	logic       wr_dst_q, wr_src_q;
	logic [8:0] dst_x_q, dst_y_q;
	logic [1:0] dst_data_q;
	logic       res_ok_q, res_read_q;
	logic [1:0] res_kind_q;

	// Output register
	logic                rsp_valid_q;
	logic                out_ok_q;
	logic [7:0]          out_x_q, out_y_q;
	logic [1:0]          out_kind_q;
	fsg_pkg::fsg_rgb_t   out_rgb_q;

	// Memory port
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [1:0]    mem_wdata, mem_rdata;
	logic [8:0]    ax, ay;

	logic req_acc, out_free, last_clr, last_rd;
	logic [8:0] x9, y9;

	assign req_acc  = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign last_clr = (clr_cnt_q == AW'(DEPTH - 1));
	assign last_rd  = (req_q != fsg_pkg::REQ_STEP) || (rd_cnt_q == fsg_pkg::PRB_LEFT);
	assign x9       = {1'b0, x_q};
	assign y9       = {1'b0, y_q};

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fsg_pkg::ST_CLEAR:     if (last_clr) state_nxt = fsg_pkg::ST_IDLE;
			fsg_pkg::ST_IDLE:      if (req_acc) state_nxt = fsg_pkg::ST_READ;
			fsg_pkg::ST_READ:      if (last_rd) state_nxt = fsg_pkg::ST_SETTLE;
			fsg_pkg::ST_SETTLE:    state_nxt = fsg_pkg::ST_EVAL;
			fsg_pkg::ST_EVAL:      state_nxt = fsg_pkg::ST_WRITE_DST;
			fsg_pkg::ST_WRITE_DST: begin
				// skip the write-back when nothing changes
				if (!wr_dst_q) begin
					state_nxt = fsg_pkg::ST_DONE;
				end else if (wr_src_q) begin
					state_nxt = fsg_pkg::ST_WRITE_SRC;
				end else begin
					state_nxt = fsg_pkg::ST_DONE;
				end
			end
			fsg_pkg::ST_WRITE_SRC: state_nxt = fsg_pkg::ST_DONE;
			fsg_pkg::ST_DONE:      if (out_free) state_nxt = fsg_pkg::ST_IDLE;
			default:               state_nxt = fsg_pkg::ST_CLEAR;
		endcase
	end

	// ---------------------------------------------------------------- outputs
	// One shared address: the sweep counter, a probe of the neighborhood, or a
	// write-back target. Only one memory access happens in any cycle.
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = 2'(fsg_pkg::KIND_AIR);
		ax        = x9;
		ay        = y9;
		case (state_q)
			fsg_pkg::ST_CLEAR: mem_we = 1'b1;
			fsg_pkg::ST_IDLE:  req.ready = 1'b1;
			fsg_pkg::ST_READ: begin
				mem_re = 1'b1;
				case (rd_cnt_q)
					fsg_pkg::PRB_DOWN:  begin ax = x9;        ay = y9 + 9'd1; end
					fsg_pkg::PRB_DR:    begin ax = x9 + 9'd1; ay = y9 + 9'd1; end
					fsg_pkg::PRB_RIGHT: begin ax = x9 + 9'd1; ay = y9;        end
					fsg_pkg::PRB_DL:    begin ax = x9 - 9'd1; ay = y9 + 9'd1; end
					fsg_pkg::PRB_LEFT:  begin ax = x9 - 9'd1; ay = y9;        end
					default:            begin ax = x9;        ay = y9;        end
				endcase
			end
			fsg_pkg::ST_WRITE_DST: begin
				mem_we    = wr_dst_q;
				mem_wdata = dst_data_q;
				ax        = dst_x_q;
				ay        = dst_y_q;
			end
			fsg_pkg::ST_WRITE_SRC: begin
				mem_we    = 1'b1;
				mem_wdata = 2'(fsg_pkg::KIND_AIR);
			end
			default: ;
		endcase
	end

	always_comb begin
		if (state_q == fsg_pkg::ST_CLEAR) begin
			mem_addr = clr_cnt_q;
		end else begin
			mem_addr = AW'(32'(ay) * 32'(GRID_WIDTH) + 32'(ax));
		end
	end

	fsg_cell_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_addr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_addr),
		.rd_data (mem_rdata)
	);

	// ---------------------------------------------------------------- evaluate
	logic       ev_ok, ev_move, ev_wr;
	logic [8:0] ev_dx, ev_dy;
	logic [1:0] ev_kind, ev_data;
	logic       down_in, right_in, left_in;

	assign down_in  = (32'(y_q) + 32'd1) < 32'(GRID_HEIGHT);
	assign right_in = (32'(x_q) + 32'd1) < 32'(GRID_WIDTH);
	assign left_in  = (x_q != 8'd0);

	always_comb begin
		ev_ok   = 1'b0;
		ev_move = 1'b0;
		ev_wr   = 1'b0;
		ev_dx   = x9;
		ev_dy   = y9;
		ev_kind = 2'(fsg_pkg::KIND_AIR);
		ev_data = mat_q;
		case (req_q)
			fsg_pkg::REQ_CREATE: begin
				if (inside_q && mat_q <= 2'(fsg_pkg::KIND_STONE) &&
					cell_q[fsg_pkg::PRB_CTR] == 2'(fsg_pkg::KIND_AIR)) begin
					ev_ok = 1'b1;
					ev_wr = 1'b1;
				end
			end
			fsg_pkg::REQ_STEP: begin
				ev_data = 2'(fsg_pkg::KIND_SAND);
				if (inside_q && down_in &&
					cell_q[fsg_pkg::PRB_CTR] == 2'(fsg_pkg::KIND_SAND)) begin
					if (cell_q[fsg_pkg::PRB_DOWN] == 2'(fsg_pkg::KIND_AIR)) begin
						ev_move = 1'b1;
						ev_dy   = y9 + 9'd1;
					end else if (right_in &&
						cell_q[fsg_pkg::PRB_DR] == 2'(fsg_pkg::KIND_AIR)) begin
						// blocked side cell stops the move; down-left is not tried
						if (cell_q[fsg_pkg::PRB_RIGHT] == 2'(fsg_pkg::KIND_AIR)) begin
							ev_move = 1'b1;
							ev_dx   = x9 + 9'd1;
							ev_dy   = y9 + 9'd1;
						end
					end else if (left_in &&
						cell_q[fsg_pkg::PRB_DL] == 2'(fsg_pkg::KIND_AIR)) begin
						if (cell_q[fsg_pkg::PRB_LEFT] == 2'(fsg_pkg::KIND_AIR)) begin
							ev_move = 1'b1;
							ev_dx   = x9 - 9'd1;
							ev_dy   = y9 + 9'd1;
						end
					end
				end
				ev_wr = ev_move;
			end
			fsg_pkg::REQ_READ: begin
				if (inside_q && cell_q[fsg_pkg::PRB_CTR] <= 2'(fsg_pkg::KIND_STONE)) begin
					ev_kind = cell_q[fsg_pkg::PRB_CTR];
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsg_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			rd_cnt_q    <= fsg_pkg::PRB_CTR;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == fsg_pkg::ST_READ);
			if (state_q == fsg_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			// advance the probe counter while fetching, rewind on accept
			if (req_acc) begin
				rd_cnt_q <= fsg_pkg::PRB_CTR;
			end else if (state_q == fsg_pkg::ST_READ && !last_rd) begin
				rd_cnt_q <= fsg_pkg::fsg_probe_t'(rd_cnt_q + 3'd1);
			end
			if (state_q == fsg_pkg::ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_tag_s1 <= rd_cnt_q;
		if (rd_vld_s1) begin
			cell_q[rd_tag_s1] <= mem_rdata;
		end
		if (req_acc) begin
			req_q    <= req.req_type;
			x_q      <= req.pos_x;
			y_q      <= req.pos_y;
			mat_q    <= req.material;
			inside_q <= (32'(req.pos_x) < 32'(GRID_WIDTH)) &&
				(32'(req.pos_y) < 32'(GRID_HEIGHT));
		end
		if (state_q == fsg_pkg::ST_EVAL) begin
			wr_dst_q   <= ev_wr;
			wr_src_q   <= ev_move;
			dst_x_q    <= ev_dx;
			dst_y_q    <= ev_dy;
			dst_data_q <= ev_data;
			res_ok_q   <= ev_ok;
			res_kind_q <= ev_kind;
			res_read_q <= (req_q == fsg_pkg::REQ_READ);
		end
		if (state_q == fsg_pkg::ST_DONE && out_free) begin
			out_ok_q   <= res_ok_q;
			// wide grids report only the low coordinate bits
			out_x_q    <= dst_x_q[7:0];
			out_y_q    <= dst_y_q[7:0];
			out_kind_q <= res_kind_q;
			out_rgb_q  <= res_read_q ? fsg_pkg::fsg_colour(res_kind_q) : '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.ok        = out_ok_q;
	assign rsp.new_x     = out_x_q;
	assign rsp.new_y     = out_y_q;
	assign rsp.cell_kind = out_kind_q;
	assign rsp.red       = out_rgb_q.red;
	assign rsp.green     = out_rgb_q.green;
	assign rsp.blue      = out_rgb_q.blue;

	// ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
	// no memory writes while a request may be accepted
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fsg_pkg::ST_IDLE) |-> !mem_we)
		else $error("cell memory written while idle");

	// a full, stalled output register holds the sequencer at its final cycle
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fsg_pkg::ST_DONE && rsp_valid_q && !rsp.ready)
		|=> (state_q == fsg_pkg::ST_DONE))
		else $error("response overwritten while stalled");

	// the source cell is cleared only after a move was written
	a_src_after_dst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fsg_pkg::ST_WRITE_SRC)
		|-> ($past(state_q) == fsg_pkg::ST_WRITE_DST && $past(mem_we)))
		else $error("source cleared without a destination write");
`endif

endmodule
